// ===== sv/ism_pkg.sv =====
package ism_pkg;

  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned DataWidth         = 32;
  localparam int unsigned OpWidth           = 3;
  localparam int unsigned StatusWidth       = 3;

  typedef enum logic [OpWidth-1:0] {
    OP_PUSH = 3'd0,
    OP_PALL = 3'd1,
    OP_PTOP = 3'd2,
    OP_POP  = 3'd3,
    OP_SWAP = 3'd4,
    OP_ADD  = 3'd5,
    OP_NOP  = 3'd6
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_SHORT  = 3'd2,
    ST_FULL   = 3'd3,
    ST_HALTED = 3'd4
  } status_e;

  typedef struct packed {
    logic                 strobe;
    logic                 print_valid;
    logic [DataWidth-1:0] value;
    status_e              status;
    logic                 last;
  } result_t;

endpackage

// ===== sv/ism_ram.sv =====
module ism_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/integer_stack_machine_unit.sv =====
// Result beats are registered. The beat of a push, pop, nop, error or halted item comes
// in the cycle after the accepting edge; print top answers from S_TOP, add from S_EXEC
// after S_RD2, and swap from S_SWB after S_RD2 and S_EXEC. Print all gives one beat per
// entry on consecutive cycles from S_PALL. The receiver cannot stall. Busy holds the next
// item off until the sequencer is idle again; a push, pop, nop, error or halted item never raises it.
// Reset (rst_ni low, asynchronous) empties the stack and clears halted, not the memory.
module integer_stack_machine_unit #(
  parameter int unsigned STACK_DEPTH = ism_pkg::StackDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [ism_pkg::OpWidth-1:0]     opcode_i,
  input  logic [ism_pkg::DataWidth-1:0]   push_value_i,
  output logic                            result_strobe_o,
  output logic                            print_valid_o,
  output logic [ism_pkg::DataWidth-1:0]   value_o,
  output logic [ism_pkg::StatusWidth-1:0] status_o,
  output logic                            last_o
);
  import ism_pkg::*;

  // Address and fill count widths follow from the stack depth. The count must
  // also hold the depth itself, hence the extra code point.
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] FullCount = CntW'(STACK_DEPTH);

  // One-hot sequencer. It never issues a RAM read and a RAM write in the same cycle,
  // so a read and a write to the same entry never overlap and no forwarding is
  // needed: writes always land before the next read issues.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TOP  = 6'b000010,  // read data holds the top entry for print top
    S_PALL = 6'b000100,  // print all walks down, one entry per cycle
    S_RD2  = 6'b001000,  // top entry arrives, second entry is being read
    S_EXEC = 6'b010000,  // second entry arrives, add or first swap write
    S_SWB  = 6'b100000   // second swap write
  } state_e;

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 halted_q, halted_d;
  logic [AddrW-1:0]     ptr_q, ptr_d;
  logic [DataWidth-1:0] top_q, top_d;
  logic                 is_add_q, is_add_d;
  result_t              res_q, res_d;

  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [DataWidth-1:0] ram_wdata;
  logic [AddrW-1:0]     ram_raddr;
  logic [DataWidth-1:0] ram_rdata;

  logic [CntW-1:0]      cnt_m1, cnt_m2;
  logic [AddrW-1:0]     idx_top, idx_sec;

  assign cnt_m1  = count_q - CntW'(1);
  assign cnt_m2  = count_q - CntW'(2);
  assign idx_top = cnt_m1[AddrW-1:0];
  assign idx_sec = cnt_m2[AddrW-1:0];

  ism_ram #(
    .Width (DataWidth),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    halted_d  = halted_q;
    ptr_d     = ptr_q;
    top_d     = top_q;
    is_add_d  = is_add_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;

    // The default result beat is an idle one; each branch that answers an
    // item raises the strobe and fills in the payload.
    res_d             = '0;
    res_d.status      = ST_OK;
    res_d.last        = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          res_d.strobe = 1'b1;
          if (halted_q) begin
            res_d.status = ST_HALTED;
          end else begin
            case (opcode_i)
              OP_PUSH: begin
                if (count_q == FullCount) begin
                  res_d.status = ST_FULL;
                  halted_d     = 1'b1;
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = count_q[AddrW-1:0];
                  ram_wdata = push_value_i;
                  count_d   = count_q + CntW'(1);
                end
              end
              OP_PALL: begin
                // An empty stack answers with one plain ok beat.
                if (count_q != '0) begin
                  res_d.strobe = 1'b0;
                  ram_raddr    = idx_top;
                  ptr_d        = idx_top;
                  state_d      = S_PALL;
                end
              end
              OP_PTOP: begin
                if (count_q == '0) begin
                  res_d.status = ST_EMPTY;
                  halted_d     = 1'b1;
                end else begin
                  res_d.strobe = 1'b0;
                  ram_raddr    = idx_top;
                  state_d      = S_TOP;
                end
              end
              OP_POP: begin
                if (count_q == '0) begin
                  res_d.status = ST_EMPTY;
                  halted_d     = 1'b1;
                end else begin
                  count_d = cnt_m1;
                end
              end
              OP_SWAP, OP_ADD: begin
                if (count_q < CntW'(2)) begin
                  res_d.status = ST_SHORT;
                  halted_d     = 1'b1;
                end else begin
                  res_d.strobe = 1'b0;
                  ram_raddr    = idx_top;
                  is_add_d     = (opcode_i == OP_ADD);
                  state_d      = S_RD2;
                end
              end
              default: begin
                // Nop, and the unused code seven, answer ok and change nothing.
              end
            endcase
          end
        end
      end
      S_TOP: begin
        res_d.strobe      = 1'b1;
        res_d.print_valid = 1'b1;
        res_d.value       = ram_rdata;
        state_d           = S_IDLE;
      end
      S_PALL: begin
        res_d.strobe      = 1'b1;
        res_d.print_valid = 1'b1;
        res_d.value       = ram_rdata;
        res_d.last        = (ptr_q == '0);
        if (ptr_q != '0) begin
          ram_raddr = ptr_q - AddrW'(1);
          ptr_d     = ptr_q - AddrW'(1);
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD2: begin
        top_d     = ram_rdata;
        ram_raddr = idx_sec;
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        ram_we = 1'b1;
        if (is_add_q) begin
          ram_waddr    = idx_sec;
          ram_wdata    = ram_rdata + top_q;
          count_d      = cnt_m1;
          res_d.strobe = 1'b1;
          state_d      = S_IDLE;
        end else begin
          ram_waddr = idx_top;
          ram_wdata = ram_rdata;
          state_d   = S_SWB;
        end
      end
      S_SWB: begin
        ram_we       = 1'b1;
        ram_waddr    = idx_sec;
        ram_wdata    = top_q;
        res_d.strobe = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      halted_q <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      halted_q <= halted_d;
      res_q    <= res_d;
    end
  end

  // Working registers need no reset.
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    top_q    <= top_d;
    is_add_q <= is_add_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign result_strobe_o = res_q.strobe;
  assign print_valid_o   = res_q.print_valid;
  assign value_o         = res_q.value;
  assign status_o        = res_q.status;
  assign last_o          = res_q.last;

endmodule

// ===== sv/ism_checker.sv =====
module ism_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            result_strobe_o,
  input logic                            print_valid_o,
  input logic [ism_pkg::DataWidth-1:0]   value_o,
  input logic [ism_pkg::StatusWidth-1:0] status_o,
  input logic                            last_o
);
  import ism_pkg::*;

  // An error or halted beat is always the only beat of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && (status_o != ST_OK) |-> last_o && !print_valid_o)
    else $error("error beat is not a single final beat");

  // A beat without a printed entry carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !print_valid_o |-> (value_o == '0))
    else $error("value not zero on a non-print beat");

  // An accepted item either answers at once or keeps the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> result_strobe_o || busy)
    else $error("accepted item neither answered nor busy");

  // Print all beats come back to back until the final one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && print_valid_o && !last_o |=> result_strobe_o && print_valid_o)
    else $error("print sequence broken");

  // Once an error is reported, an ok beat never follows in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && (status_o != ST_OK) |=> !(result_strobe_o && (status_o == ST_OK)))
    else $error("ok beat after an error");

endmodule

bind integer_stack_machine_unit ism_checker u_ism_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .print_valid_o   (print_valid_o),
  .value_o         (value_o),
  .status_o        (status_o),
  .last_o          (last_o)
);

// ===== tb/sv/integer_stack_machine_unit_test.sv =====
`timescale 1ns / 100ps

module integer_stack_machine_unit_test;
  import ism_pkg::*;

  // The stack is checked at its full default depth.
  localparam int unsigned Depth = StackDepthDefault;

  // Opcode seven is not part of the instruction set and must behave as a nop.
  localparam logic [OpWidth-1:0] OpUnused = 3'd7;

  // The slowest correct run is far below this: about 500 instructions, each with at most
  // 64 result beats, plus the sender gaps and the block latency.
  localparam int unsigned CycleLimit = 500000;

  // Cycles to wait after the last expected beat for any stray beat to show up.
  localparam int unsigned DrainCycles = 10;

  // One expected result beat, field by field.
  typedef struct {
    logic                 print_valid;
    logic [DataWidth-1:0] value;
    status_e              status;
    logic                 last;
  } beat_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [OpWidth-1:0]     opcode_i;
  logic [DataWidth-1:0]   push_value_i;
  logic                   result_strobe_o;
  logic                   print_valid_o;
  logic [DataWidth-1:0]   value_o;
  logic [StatusWidth-1:0] status_o;
  logic                   last_o;

  // Shadow copy of the machine: stack contents, fill level and the sticky halt flag.
  logic [DataWidth-1:0] stack_mem [Depth];
  int unsigned          stack_count;
  bit                   halted_flag;

  // Beats the block still owes us, oldest first.
  beat_t expected_beats [$];

  int unsigned error_count;
  int unsigned cycle_count;

  // When cleared, the sender issues instructions back to back.
  bit gaps_on;

  integer_stack_machine_unit #(
    .STACK_DEPTH(Depth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .push_value_i   (push_value_i),
    .result_strobe_o(result_strobe_o),
    .print_valid_o  (print_valid_o),
    .value_o        (value_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Run-length guard. A hang anywhere in the flow ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("integer_stack_machine_unit_test: done, errors");
      $finish;
    end
  end

  // Append one expected beat to the queue.
  function automatic void expect_beat(logic pv, logic [DataWidth-1:0] val, status_e st,
                                      logic lst);
    beat_t b;
    b.print_valid = pv;
    b.value       = val;
    b.status      = st;
    b.last        = lst;
    expected_beats.push_back(b);
  endfunction

  // An error answers with a single status beat, leaves the stack alone and halts the machine.
  function automatic void trap(status_e st);
    halted_flag = 1'b1;
    expect_beat(1'b0, '0, st, 1'b1);
  endfunction

  // Execute one accepted instruction on the shadow machine and queue the beats it causes.
  function automatic void execute_instr(logic [OpWidth-1:0] op, logic [DataWidth-1:0] operand);
    logic [DataWidth-1:0] tmp;
    if (halted_flag) begin
      expect_beat(1'b0, '0, ST_HALTED, 1'b1);
      return;
    end
    case (op)
      OP_PUSH: begin
        if (stack_count >= Depth) begin
          trap(ST_FULL);
          return;
        end
        stack_mem[stack_count] = operand;
        stack_count++;
      end
      OP_PALL: begin
        // A non-empty stack is listed top first, one beat per entry, last on the bottom entry.
        // An empty stack still gets one plain ok beat below.
        if (stack_count != 0) begin
          for (int k = 0; k < int'(stack_count); k++) begin
            expect_beat(1'b1, stack_mem[stack_count - 1 - k], ST_OK,
                        k == int'(stack_count) - 1);
          end
          return;
        end
      end
      OP_PTOP: begin
        if (stack_count == 0) begin
          trap(ST_EMPTY);
          return;
        end
        expect_beat(1'b1, stack_mem[stack_count - 1], ST_OK, 1'b1);
        return;
      end
      OP_POP: begin
        if (stack_count == 0) begin
          trap(ST_EMPTY);
          return;
        end
        stack_count--;
      end
      OP_SWAP: begin
        if (stack_count < 2) begin
          trap(ST_SHORT);
          return;
        end
        tmp                        = stack_mem[stack_count - 1];
        stack_mem[stack_count - 1] = stack_mem[stack_count - 2];
        stack_mem[stack_count - 2] = tmp;
      end
      OP_ADD: begin
        if (stack_count < 2) begin
          trap(ST_SHORT);
          return;
        end
        // The sum wraps at 32 bits.
        stack_mem[stack_count - 2] = stack_mem[stack_count - 2] + stack_mem[stack_count - 1];
        stack_count--;
      end
      default: begin
        // Nop and the unused opcode change nothing.
      end
    endcase
    expect_beat(1'b0, '0, ST_OK, 1'b1);
  endfunction

  // Sender gap in cycles: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Push operand: the corner values often, otherwise any 32-bit word.
  function automatic logic [DataWidth-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Pick an opcode that cannot trap at the current fill level.
  function automatic logic [OpWidth-1:0] pick_safe_op();
    int unsigned r;
    logic [OpWidth-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 30)      op = OP_PUSH;
    else if (r < 38) op = OP_PALL;
    else if (r < 50) op = OP_PTOP;
    else if (r < 65) op = OP_POP;
    else if (r < 77) op = OP_SWAP;
    else if (r < 90) op = OP_ADD;
    else if (r < 95) op = OP_NOP;
    else             op = OpUnused;
    if ((op == OP_PUSH && stack_count >= Depth) ||
        ((op == OP_PTOP || op == OP_POP) && stack_count < 1) ||
        ((op == OP_SWAP || op == OP_ADD) && stack_count < 2)) begin
      op = (stack_count < Depth) ? OP_PUSH : OP_POP;
    end
    return op;
  endfunction

  // Send one instruction beat. The fields change at the falling edge; the beat is taken at the
  // first rising edge with start high and busy low. A following gap drops start for a while.
  // With no gap, start simply stays high into the next call.
  task automatic send_instr(input logic [OpWidth-1:0] op, input logic [DataWidth-1:0] operand);
    int unsigned gap;
    @(negedge clk_i);
    start        <= 1'b1;
    opcode_i     <= op;
    push_value_i <= operand;
    do @(posedge clk_i); while (busy);
    execute_instr(op, operand);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Result checker. Every strobed beat must match the oldest expectation, field by field.
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && result_strobe_o) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: print_valid %0b value %h status %0d last %0b",
               print_valid_o, value_o, status_o, last_o);
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        if (print_valid_o !== want.print_valid) begin
          $error("print_valid: expected %0b, got %0b", want.print_valid, print_valid_o);
          error_count++;
        end
        if (value_o !== want.value) begin
          $error("value: expected %h, got %h", want.value, value_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          error_count++;
        end
      end
    end
  end

  // Print all on an empty stack, plus nop and the unused opcode.
  task automatic test_empty_stack();
    send_instr(OP_PALL, '0);
    send_instr(OP_NOP, 32'hffff_ffff);
    send_instr(OpUnused, 32'h5a5a_a5a5);
  endtask

  // Extreme push values, printing, swap, adds that wrap, and pops back to empty.
  task automatic test_directed_ops();
    send_instr(OP_PUSH, 32'h8000_0000);
    send_instr(OP_PUSH, 32'h7fff_ffff);
    send_instr(OP_PUSH, 32'h0000_0000);
    send_instr(OP_PUSH, 32'hffff_ffff);
    send_instr(OP_PTOP, '0);
    send_instr(OP_PALL, '0);
    send_instr(OP_SWAP, '0);
    send_instr(OP_PTOP, '0);
    send_instr(OP_ADD, '0);
    send_instr(OP_ADD, '0);
    send_instr(OP_PALL, '0);
    send_instr(OP_ADD, '0);
    send_instr(OP_PTOP, '0);
    send_instr(OP_POP, '0);
    // Largest positive plus one wraps to the most negative value.
    send_instr(OP_PUSH, 32'h7fff_ffff);
    send_instr(OP_PUSH, 32'h0000_0001);
    send_instr(OP_ADD, '0);
    send_instr(OP_PALL, '0);
    send_instr(OP_POP, '0);
    send_instr(OP_PALL, '0);
  endtask

  // Random programs that never trap, with stretches of back-to-back beats.
  task automatic test_random_program(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      send_instr(pick_safe_op(), pick_word());
    end
    gaps_on = 1'b1;
  endtask

  // Fill the stack to its last slot, list it, then work on the full stack without trapping.
  task automatic test_full_depth();
    while (stack_count < Depth) send_instr(OP_PUSH, pick_word());
    send_instr(OP_PALL, '0);
    send_instr(OP_SWAP, '0);
    send_instr(OP_PTOP, '0);
    send_instr(OP_ADD, '0);
    send_instr(OP_PUSH, 32'h8000_0000);
    repeat ($urandom_range(10, 50)) send_instr(OP_POP, '0);
    send_instr(OP_PALL, '0);
  endtask

  // Only reset clears the halt, and reset happens once, so one error kind is chosen per run:
  // popping or printing an empty stack, swap or add on fewer than two entries, or push when
  // full. Every instruction after it must answer with the halted status alone.
  task automatic test_error_and_halt();
    case ($urandom_range(0, 2))
      0: begin
        while (stack_count > 0) send_instr(OP_POP, '0);
        send_instr($urandom_range(0, 1) ? OP_POP : OP_PTOP, '0);
      end
      1: begin
        while (stack_count > 1) send_instr($urandom_range(0, 1) ? OP_POP : OP_ADD, '0);
        send_instr($urandom_range(0, 1) ? OP_SWAP : OP_ADD, '0);
      end
      default: begin
        while (stack_count < Depth) send_instr(OP_PUSH, pick_word());
        send_instr(OP_PUSH, pick_word());
      end
    endcase
    for (int unsigned op = 0; op < 8; op++) send_instr(op[OpWidth-1:0], pick_word());
    repeat (8) send_instr(OpWidth'($urandom_range(0, 7)), pick_word());
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    opcode_i     = '0;
    push_value_i = '0;
    stack_count  = 0;
    halted_flag  = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    gaps_on      = 1'b1;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_stack();
    test_directed_ops();
    test_random_program(280);
    test_full_depth();
    test_error_and_halt();

    @(negedge clk_i);
    start <= 1'b0;

    // Wait for the last beats, then a little longer to catch anything extra.
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("integer_stack_machine_unit_test: done, clean");
    end else begin
      $display("integer_stack_machine_unit_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ism_pkg.sv
sv/ism_ram.sv
sv/integer_stack_machine_unit.sv
sv/ism_checker.sv
tb/sv/integer_stack_machine_unit_test.sv
